>>> rtl/rmw_pkg.sv
// Shared types and constants for the range mex window engine.
package rmw_pkg;

  // Field widths of the stream words.
  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 10;
  localparam int unsigned MEX_W = 11;
  localparam int unsigned IN_TDATA_W = 48;
  localparam int unsigned OUT_TDATA_W = 16;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Kind of count update requested from the count unit.
  typedef enum logic {
    CNT_IN  = 1'b0,
    CNT_OUT = 1'b1
  } cnt_kind_e;

  // One unpacked input word.
  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] element_value;
    logic [POS_W-1:0] range_left;
    logic [POS_W-1:0] range_right;
  } item_t;

  // Request from the sequencer to the count unit.
  typedef struct packed {
    logic             valid;
    cnt_kind_e        kind;
    logic [VAL_W-1:0] value;
  } cnt_req_t;

  // Result strobe from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic bad;
  } res_t;

endpackage

>>> rtl/range_mex_window_engine.sv
// A write outside the window only stores the element; one inside it also updates the counts
// and may walk the mex; a query steps the window ends one position at a time before its answer.
// Throughput: one word at a time; the next word waits until the current one is done, and
// the window walk in the sequencer sets the cost.
// Reset: asynchronous, active low; a clearing pass over all VALUE_RANGE entries then
// zeroes the count memory, and no input word is taken until it ends.
module range_mex_window_engine #(
  parameter int unsigned POSITIONS   = 1024,
  parameter int unsigned VALUE_RANGE = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position [10:0], element_value [20:11], range_left [31:21], range_right [42:32]
  input  logic [rmw_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // op
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // mex [10:0]
  output logic [rmw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // bad_range
  output logic                              m_axis_tuser_o
);

  rmw_pkg::item_t                 item;
  rmw_pkg::cnt_req_t              cu_req;
  rmw_pkg::res_t                  res;
  logic                           cu_idle;
  logic [rmw_pkg::MEX_W-1:0]      cu_mex;
  logic                           out_free;

  logic                           out_valid_q, out_valid_d;
  logic [rmw_pkg::MEX_W-1:0]      out_mex_q, out_mex_d;
  logic                           out_bad_q, out_bad_d;

  // Unpack the input word.
  assign item.op            = s_axis_tuser_i;
  assign item.position      = s_axis_tdata_i[10:0];
  assign item.element_value = s_axis_tdata_i[20:11];
  assign item.range_left    = s_axis_tdata_i[31:21];
  assign item.range_right   = s_axis_tdata_i[42:32];

  rmw_seq #(
    .POSITIONS (POSITIONS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .cu_idle_i    (cu_idle),
    .cu_req_o     (cu_req),
    .out_free_i   (out_free),
    .res_o        (res)
  );

  rmw_count_unit #(
    .VALUE_RANGE (VALUE_RANGE),
    .POSITIONS   (POSITIONS)
  ) u_count (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cu_req),
    .idle_o (cu_idle),
    .mex_o  (cu_mex)
  );

  // Output register; a held result frees the slot once it is taken.
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_mex_d   = out_mex_q;
    out_bad_d   = out_bad_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_bad_d   = res.bad;
      out_mex_d   = res.bad ? '0 : cu_mex;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mex_q <= out_mex_d;
    out_bad_q <= out_bad_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = rmw_pkg::OUT_TDATA_W'(out_mex_q);
  assign m_axis_tuser_o  = out_bad_q;

endmodule

>>> rtl/rmw_count_unit.sv
// Value count memory, current mex register and the shared step adder.
module rmw_count_unit #(
  parameter int unsigned VALUE_RANGE = 1024,
  parameter int unsigned POSITIONS   = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rmw_pkg::cnt_req_t        req_i,
  output logic                     idle_o,
  output logic [rmw_pkg::MEX_W-1:0] mex_o
);

  localparam int unsigned VAW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
  localparam int unsigned MW  = $clog2(VALUE_RANGE + 1);
  localparam int unsigned CW  = $clog2(POSITIONS + 1);
  localparam int unsigned SW  = (CW > MW) ? CW : MW;

  typedef enum logic [4:0] {
    C_CLEAR = 5'b00001,
    C_IDLE  = 5'b00010,
    C_RD    = 5'b00100,
    C_BUMP  = 5'b01000,
    C_WALK  = 5'b10000
  } cu_state_e;

  cu_state_e                   state_q, state_d;
  logic [MW-1:0]               mex_q, mex_d;
  logic [VAW-1:0]              clr_q, clr_d;
  logic [rmw_pkg::VAL_W-1:0]   val_q, val_d;
  rmw_pkg::cnt_kind_e          kind_q, kind_d;

  logic [CW-1:0]  cnt_mem [VALUE_RANGE];
  logic [CW-1:0]  rd_q;
  logic           we, re;
  logic [VAW-1:0] waddr, raddr;
  logic [CW-1:0]  wdata;

  logic [SW-1:0]  add_a, add_sum;
  logic           add_neg;

  // Shared step adder: adds one or minus one.
  assign add_sum = add_a + (add_neg ? {SW{1'b1}} : SW'(1));

  // Count memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= cnt_mem[raddr];
    end
  end

  // Sequencer of the count unit.
  always_comb begin
    state_d = state_q;
    mex_d   = mex_q;
    clr_d   = clr_q;
    val_d   = val_q;
    kind_d  = kind_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = VAW'(val_q);
    raddr   = VAW'(req_i.value);
    wdata   = '0;
    add_a   = SW'(rd_q);
    add_neg = 1'b0;
    case (state_q)
      C_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + VAW'(1);
        if (clr_q == VAW'(VALUE_RANGE - 1)) begin
          state_d = C_IDLE;
        end
      end
      C_IDLE: begin
        // Values beyond the value range are not counted at all.
        if (req_i.valid && (req_i.value < VALUE_RANGE)) begin
          re      = 1'b1;
          val_d   = req_i.value;
          kind_d  = req_i.kind;
          state_d = C_RD;
        end
      end
      C_RD: begin
        if (kind_q == rmw_pkg::CNT_IN) begin
          we    = 1'b1;
          wdata = CW'(add_sum);
          // The mex only moves when its own value becomes present.
          if (val_q == mex_q) begin
            state_d = C_BUMP;
          end else begin
            state_d = C_IDLE;
          end
        end else begin
          add_neg = 1'b1;
          if (rd_q != '0) begin
            we    = 1'b1;
            wdata = CW'(add_sum);
          end
          if ((rd_q <= CW'(1)) && (val_q < mex_q)) begin
            mex_d = MW'(val_q);
          end
          state_d = C_IDLE;
        end
      end
      C_BUMP: begin
        add_a = SW'(mex_q);
        mex_d = MW'(add_sum);
        if (add_sum < VALUE_RANGE) begin
          re      = 1'b1;
          raddr   = VAW'(add_sum);
          state_d = C_WALK;
        end else begin
          state_d = C_IDLE;
        end
      end
      C_WALK: begin
        if (rd_q != '0) begin
          state_d = C_BUMP;
        end else begin
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_CLEAR;
      mex_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      mex_q   <= mex_d;
      clr_q   <= clr_d;
    end
  end

  // Payload registers of the pending request.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    kind_q <= kind_d;
  end

  assign idle_o = (state_q == C_IDLE);
  assign mex_o  = rmw_pkg::MEX_W'(mex_q);

`ifndef SYNTHESIS
  a_mex_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mex_q <= VALUE_RANGE)
    else $error("mex register beyond value range");

  a_rd_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_RD |-> $past(state_q == C_IDLE && req_i.valid))
    else $error("count read without a request");

  a_walk_after_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == C_WALK |-> $past(state_q == C_BUMP))
    else $error("mex walk not preceded by a bump");

  a_mex_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(mex_q) |-> $past(state_q == C_RD || state_q == C_BUMP))
    else $error("mex changed outside an update step");
`endif

endmodule

>>> rtl/rmw_seq.sv
// Item sequencer: element memory, window pointers and count requests.
module rmw_seq #(
  parameter int unsigned POSITIONS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  rmw_pkg::item_t       item_i,
  input  logic                 cu_idle_i,
  output rmw_pkg::cnt_req_t    cu_req_o,
  input  logic                 out_free_i,
  output rmw_pkg::res_t        res_o
);

  localparam int unsigned AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int unsigned PW = rmw_pkg::POS_W;
  localparam int unsigned VW = rmw_pkg::VAL_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_STEP   = 8'b00000010,
    S_FETCH  = 8'b00000100,
    S_WAIT   = 8'b00001000,
    S_WFETCH = 8'b00010000,
    S_WOUT   = 8'b00100000,
    S_WIN    = 8'b01000000,
    S_RESULT = 8'b10000000
  } seq_state_e;

  seq_state_e          state_q, state_d;
  logic [PW-1:0]       wl_q, wl_d, wr_q, wr_d;
  logic [PW-1:0]       ql_q, ql_d, qr_q, qr_d;
  logic [PW-1:0]       wpos_q, wpos_d;
  logic [VW-1:0]       wval_q, wval_d;
  rmw_pkg::cnt_kind_e  kind_q, kind_d;
  logic                bad_q, bad_d;

  logic [VW-1:0]       elem_mem [POSITIONS];
  logic [VW-1:0]       elem_rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [VW-1:0]       mem_wdata;

  logic                accept;
  logic [PW-1:0]       cl_left, cl_right;

  // Saturate a query end into the valid position range.
  function automatic logic [PW-1:0] clamp_pos(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = p;
    if (p == '0) begin
      r = PW'(1);
    end else if (p > POSITIONS) begin
      r = PW'(POSITIONS);
    end
    return r;
  endfunction

  assign cl_left      = clamp_pos(item_i.range_left);
  assign cl_right     = clamp_pos(item_i.range_right);
  assign item_ready_o = (state_q == S_IDLE) && cu_idle_i;
  assign accept       = item_valid_i && item_ready_o;

  // Element memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      elem_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      elem_rd_q <= elem_mem[mem_raddr];
    end
  end

  // Window walk and write handling.
  always_comb begin
    state_d   = state_q;
    wl_d      = wl_q;
    wr_d      = wr_q;
    ql_d      = ql_q;
    qr_d      = qr_q;
    wpos_d    = wpos_q;
    wval_d    = wval_q;
    kind_d    = kind_q;
    bad_d     = bad_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(wpos_q - PW'(1));
    mem_wdata = wval_q;
    mem_raddr = AW'(item_i.position - PW'(1));
    cu_req_o  = '0;
    res_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.op == rmw_pkg::OP_WRITE) begin
            // Writes to positions outside the array are dropped.
            if ((item_i.position != '0) && (item_i.position <= POSITIONS)) begin
              if ((item_i.position >= wl_q) && (item_i.position <= wr_q)) begin
                mem_re  = 1'b1;
                wpos_d  = item_i.position;
                wval_d  = item_i.element_value;
                state_d = S_WFETCH;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(item_i.position - PW'(1));
                mem_wdata = item_i.element_value;
              end
            end
          end else if (cl_left > cl_right) begin
            bad_d   = 1'b1;
            state_d = S_RESULT;
          end else begin
            ql_d    = cl_left;
            qr_d    = cl_right;
            bad_d   = 1'b0;
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        // Grow the window first, then shrink it, one position per step.
        if (wl_q > ql_q) begin
          wl_d      = wl_q - PW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(wl_q - PW'(2));
          kind_d    = rmw_pkg::CNT_IN;
          state_d   = S_FETCH;
        end else if (wr_q < qr_q) begin
          wr_d      = wr_q + PW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(wr_q);
          kind_d    = rmw_pkg::CNT_IN;
          state_d   = S_FETCH;
        end else if (wl_q < ql_q) begin
          wl_d      = wl_q + PW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(wl_q - PW'(1));
          kind_d    = rmw_pkg::CNT_OUT;
          state_d   = S_FETCH;
        end else if (wr_q > qr_q) begin
          wr_d      = wr_q - PW'(1);
          mem_re    = 1'b1;
          mem_raddr = AW'(wr_q - PW'(1));
          kind_d    = rmw_pkg::CNT_OUT;
          state_d   = S_FETCH;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_FETCH: begin
        cu_req_o.valid = 1'b1;
        cu_req_o.kind  = kind_q;
        cu_req_o.value = elem_rd_q;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        if (cu_idle_i) begin
          state_d = S_STEP;
        end
      end
      S_WFETCH: begin
        // Drop the old value and store the new one in the same cycle.
        cu_req_o.valid = 1'b1;
        cu_req_o.kind  = rmw_pkg::CNT_OUT;
        cu_req_o.value = elem_rd_q;
        mem_we         = 1'b1;
        state_d        = S_WOUT;
      end
      S_WOUT: begin
        if (cu_idle_i) begin
          cu_req_o.valid = 1'b1;
          cu_req_o.kind  = rmw_pkg::CNT_IN;
          cu_req_o.value = wval_q;
          state_d        = S_WIN;
        end
      end
      S_WIN: begin
        if (cu_idle_i) begin
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          res_o.bad   = bad_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wl_q    <= PW'(1);
      wr_q    <= '0;
    end else begin
      state_q <= state_d;
      wl_q    <= wl_d;
      wr_q    <= wr_d;
    end
  end

  // Payload registers of the item in work.
  always_ff @(posedge clk_i) begin
    ql_q   <= ql_d;
    qr_q   <= qr_d;
    wpos_q <= wpos_d;
    wval_q <= wval_d;
    kind_q <= kind_d;
    bad_q  <= bad_d;
  end

endmodule

>>> test/range_mex_window_engine_tb.sv
// Self-checking testbench for the range mex window engine with random stream handshakes.
module range_mex_window_engine_tb;

  localparam int unsigned POSITIONS   = 1024;
  localparam int unsigned VALUE_RANGE = 1024;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned RANDOM_WORDS = 650;

  // Expected answer of one range query.
  typedef struct packed {
    logic [rmw_pkg::MEX_W-1:0] mex;
    logic                      bad;
  } mex_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [rmw_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [rmw_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            m_tuser;

  // Shadow state of the engine: elements, value counts, window and mex.
  bit [rmw_pkg::VAL_W-1:0] elem_mem [1:POSITIONS];
  int unsigned    val_cnt [0:VALUE_RANGE-1];
  int unsigned    win_lo = 1;
  int unsigned    win_hi = 0;
  int unsigned    win_mex = 0;

  mex_result_t mex_expect_q[$];
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;
  int          burst_left = 0;
  bit          hold_off_req = 1'b0;
  int unsigned ready_mode = 0;
  int unsigned ready_mode_left = 0;

  range_mex_window_engine #(
    .POSITIONS  (POSITIONS),
    .VALUE_RANGE(VALUE_RANGE)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  // Free-running clock, period 2.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Adds one value to the window and walks the mex up past present values.
  function automatic void count_add(input int unsigned v);
    if (v >= VALUE_RANGE) return;
    val_cnt[v]++;
    while (win_mex < VALUE_RANGE && val_cnt[win_mex] != 0) win_mex++;
  endfunction

  // Removes one value from the window; the mex drops to it when it vanishes.
  function automatic void count_drop(input int unsigned v);
    if (v >= VALUE_RANGE) return;
    if (val_cnt[v] != 0) val_cnt[v]--;
    if (val_cnt[v] == 0 && v < win_mex) win_mex = v;
  endfunction

  function automatic int unsigned clamp_end(input int p);
    if (p < 1) return 1;
    if (p > int'(POSITIONS)) return POSITIONS;
    return p;
  endfunction

  // Updates the shadow state for one accepted word and queues any answer.
  function automatic void predict_word(input rmw_pkg::item_t w);
    int unsigned lo;
    int unsigned hi;
    mex_result_t res;
    if (w.op == rmw_pkg::OP_WRITE) begin
      if (w.position >= 1 && w.position <= POSITIONS) begin
        if (w.position >= win_lo && w.position <= win_hi) begin
          count_drop(elem_mem[w.position]);
          elem_mem[w.position] = w.element_value;
          count_add(w.element_value);
        end else begin
          elem_mem[w.position] = w.element_value;
        end
      end
    end else begin
      lo = clamp_end(int'(w.range_left));
      hi = clamp_end(int'(w.range_right));
      if (lo > hi) begin
        res.mex = '0;
        res.bad = 1'b1;
      end else begin
        // Grow both ends first, then shrink, as the engine does.
        while (win_lo > lo) begin
          win_lo--;
          count_add(elem_mem[win_lo]);
        end
        while (win_hi < hi) begin
          win_hi++;
          count_add(elem_mem[win_hi]);
        end
        while (win_lo < lo) begin
          count_drop(elem_mem[win_lo]);
          win_lo++;
        end
        while (win_hi > hi) begin
          count_drop(elem_mem[win_hi]);
          win_hi--;
        end
        res.mex = win_mex[rmw_pkg::MEX_W-1:0];
        res.bad = 1'b0;
      end
      mex_expect_q.push_back(res);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Offers one word in bursts with random gaps and predicts it on acceptance.
  task automatic send_word(input rmw_pkg::item_t w);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, w.range_right, w.range_left, w.element_value, w.position};
    s_tuser  <= w.op;
    do @(posedge clk); while (!s_tready);
    predict_word(w);
    @(negedge clk);
  endtask

  task automatic write_elem(input int unsigned pos, input int unsigned val);
    rmw_pkg::item_t w;
    w.op            = rmw_pkg::OP_WRITE;
    w.position      = pos[rmw_pkg::POS_W-1:0];
    w.element_value = val[rmw_pkg::VAL_W-1:0];
    w.range_left    = rmw_pkg::POS_W'($urandom_range(0, 2047));
    w.range_right   = rmw_pkg::POS_W'($urandom_range(0, 2047));
    send_word(w);
  endtask

  task automatic ask_range(input int unsigned left, input int unsigned right);
    rmw_pkg::item_t w;
    w.op            = rmw_pkg::OP_QUERY;
    w.position      = rmw_pkg::POS_W'($urandom_range(0, 2047));
    w.element_value = rmw_pkg::VAL_W'($urandom_range(0, 1023));
    w.range_left    = left[rmw_pkg::POS_W-1:0];
    w.range_right   = right[rmw_pkg::POS_W-1:0];
    send_word(w);
  endtask

  // Stops offering words until every queued answer has come back.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (mex_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Picks a query range near the current window, keeping it narrow.
  task automatic ask_near_window();
    int lo;
    int width;
    int unsigned hi;
    lo = int'(clamp_end(int'(win_lo) + int'($urandom_range(0, 16)) - 8));
    width = (win_hi >= win_lo) ? int'(win_hi - win_lo) : 0;
    width = width + int'($urandom_range(0, 16)) - 8;
    if (width < 0) width = 0;
    if (width > 72) width = 72;
    hi = clamp_end(lo + width);
    ask_range(lo, hi);
  endtask

  // Ignored writes, value extremes, saturated and inverted ends over the first six positions.
  task automatic test_directed_edges();
    write_elem(0, 1023);
    write_elem(2047, 1023);
    write_elem(POSITIONS + 1, 5);
    write_elem(1, 0);
    write_elem(2, 1);
    write_elem(3, 1023);
    write_elem(4, 2);
    write_elem(5, 0);
    write_elem(6, 3);
    ask_range(1, 1);
    ask_range(0, 2);
    ask_range(2, 4);
    ask_range(1, 6);
    // Writes inside the window replace a counted value.
    write_elem(3, 0);
    write_elem(2, 1023);
    ask_range(1, 6);
    ask_range(5, 4);
    ask_range(2047, 0);
    ask_range(POSITIONS, 1);
    ask_range(6, 6);
    ask_range(3, 3);
    wait_drain();
  endtask

  // Fills the whole array with a permutation so the full range reaches the top mex.
  task automatic test_fill_and_full_range();
    for (int unsigned p = 1; p <= POSITIONS; p++) write_elem(p, p - 1);
    ask_range(0, 2047);
    ask_range(1, 8);
    wait_drain();
  endtask

  // Long receiver hold-off while queries keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) ask_near_window();
    wait_drain();
  endtask

  // Mostly local queries and writes near the window, with jumps and odd ends.
  task automatic test_random_mix(input int unsigned count);
    int unsigned n;
    int unsigned kind;
    int unsigned sub;
    int unsigned width;
    int unsigned p;
    int unsigned v;
    int unsigned l;
    int unsigned r;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 15);
      if (kind < 6) begin
        width = (win_hi >= win_lo) ? win_hi - win_lo : 0;
        if ($urandom_range(0, 3) != 0)
          p = clamp_end(int'(win_lo) - 4 + int'($urandom_range(0, width + 8)));
        else
          p = $urandom_range(1, POSITIONS);
        v = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
        write_elem(p, v);
        n++;
      end else if (kind == 6) begin
        // Out-of-range write position; the engine drops it.
        p = $urandom_range(0, 1) ? 0 : $urandom_range(POSITIONS + 1, 2047);
        write_elem(p, $urandom_range(0, 1023));
      end else begin
        sub = $urandom_range(0, 63);
        if (sub == 0) begin
          l = $urandom_range(1, POSITIONS);
          ask_range(l, clamp_end(l + $urandom_range(0, 63)));
        end else if (sub == 1) begin
          ask_range(0, $urandom_range(1, 48));
        end else if (sub == 2) begin
          ask_range($urandom_range(980, POSITIONS), $urandom_range(POSITIONS + 1, 2047));
        end else if (sub < 8) begin
          l = $urandom_range(2, 2047);
          r = $urandom_range(0, clamp_end(l) - 1);
          ask_range(l, r);
        end else begin
          ask_near_window();
        end
        n++;
      end
    end
    wait_drain();
  endtask

  // Receiver readiness: changing random patterns plus an occasional long hold-off.
  always begin
    @(negedge clk);
    if (hold_off_req) begin
      m_tready <= 1'b0;
      for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
      hold_off_req = 1'b0;
      m_tready <= 1'b1;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_mode_left = $urandom_range(50, 300);
      end
      ready_mode_left--;
      case (ready_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Compares each accepted answer with the oldest queued prediction.
  always @(posedge clk) begin : check_results
    mex_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (mex_expect_q.size() == 0) begin
        report_mismatch($sformatf("answer %0d arrived with none pending", result_index));
      end else begin
        want = mex_expect_q.pop_front();
        if (m_tdata[rmw_pkg::MEX_W-1:0] !== want.mex)
          report_mismatch($sformatf("answer %0d mex %0d, wanted %0d", result_index,
                                    m_tdata[rmw_pkg::MEX_W-1:0], want.mex));
        if (m_tuser !== want.bad)
          report_mismatch($sformatf("answer %0d bad_range %b, wanted %b", result_index,
                                    m_tuser, want.bad));
      end
      result_index++;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_fill_and_full_range();
    test_backpressure();
    test_random_mix(RANDOM_WORDS);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && mex_expect_q.size() == 0) begin
      $display("range_mex_window_engine verification clean");
    end else begin
      $display("range_mex_window_engine verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("range_mex_window_engine verification failed");
    $finish;
  end

endmodule
